// ===== src/irpd_pkg.sv =====
`default_nettype none

package irpd_pkg;

    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int WORD_W  = 16;

    typedef logic [1:0] mode_t;
    typedef logic [3:0] snake_t;
    typedef logic [4:0] sweep_t;
    typedef logic [5:0] rnd_t;

    localparam mode_t MODE_OFF   = 2'd0;
    localparam mode_t MODE_ONE   = 2'd1;
    localparam mode_t MODE_TWO   = 2'd2;
    localparam mode_t MODE_THREE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_A         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_C         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UP        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN      = 3'd6;

    localparam logic [CFG_W-1:0] RST_THRESHOLD = 16'd3400;
    localparam logic [CFG_W-1:0] RST_POWER     = 16'h629D;
    localparam logic [CFG_W-1:0] RST_A         = 16'h22DD;
    localparam logic [CFG_W-1:0] RST_B         = 16'h02FD;
    localparam logic [CFG_W-1:0] RST_C         = 16'hC23D;
    localparam logic [CFG_W-1:0] RST_UP        = 16'h9867;
    localparam logic [CFG_W-1:0] RST_DOWN      = 16'h38C7;

    localparam mode_t  RST_MODE_BEFORE = MODE_TWO;
    localparam snake_t RST_SNAKE       = 4'd4;
    localparam sweep_t RST_SWEEP       = 5'd10;
    localparam rnd_t   RST_RANDOM      = 6'd10;

    localparam snake_t SNAKE_MAX = 4'd10;
    localparam snake_t SNAKE_MIN = 4'd1;
    localparam snake_t SNAKE_STEP = 4'd1;
    localparam sweep_t SWEEP_MAX = 5'd20;
    localparam sweep_t SWEEP_MIN = 5'd5;
    localparam sweep_t SWEEP_STEP = 5'd2;
    localparam rnd_t   RANDOM_MAX = 6'd60;
    localparam rnd_t   RANDOM_MIN = 6'd4;
    localparam rnd_t   RANDOM_STEP = 6'd4;

    typedef struct packed {
        logic [CFG_W-1:0] power;
        logic [CFG_W-1:0] a;
        logic [CFG_W-1:0] b;
        logic [CFG_W-1:0] c;
        logic [CFG_W-1:0] up;
        logic [CFG_W-1:0] down;
    } cfg_codes_t;

    typedef struct packed {
        logic   unknown;
        logic   clear;
        mode_t  mode;
        snake_t snake;
        sweep_t sweep;
        rnd_t   random;
    } mode_status_t;

endpackage

`default_nettype wire

// ===== src/irpd_frame_collector.sv =====
`default_nettype none

module irpd_frame_collector #(
    parameter int FRAME_EDGES = 36,
    parameter int CODE_BITS   = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step_en,
    input  wire logic                 bit_in,
    output logic                      frame_done,
    output logic [CODE_BITS-1:0]      code
);

    localparam int CNT_W = $clog2(FRAME_EDGES);
    localparam int SH_W  = CODE_BITS + 1;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [SH_W-1:0]  shift_reg, shift_next;

    assign frame_done = (count_reg == CNT_W'(FRAME_EDGES - 1));
    assign code       = shift_reg[SH_W-1:1];

    always_comb begin
        count_next = count_reg;
        shift_next = shift_reg;
        if (step_en) begin
            if (frame_done) begin
                count_next = '0;
                shift_next = '0;
            end else begin
                count_next = count_reg + CNT_W'(1);
                shift_next = {shift_reg[SH_W-2:0], bit_in};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            shift_reg <= '0;
        end else begin
            count_reg <= count_next;
            shift_reg <= shift_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/irpd_mode_ctrl.sv =====
`default_nettype none

module irpd_mode_ctrl #(
    parameter int CODE_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step_en,
    input  wire logic                 frame_evt,
    input  wire logic [CODE_BITS-1:0] code,
    input  wire irpd_pkg::cfg_codes_t codes,
    output irpd_pkg::mode_status_t    status
);

    import irpd_pkg::*;

    localparam int CMP_W = (CODE_BITS > CFG_W) ? CODE_BITS : CFG_W;

    mode_t  mode_reg, mode_next;
    mode_t  before_reg, before_next;
    snake_t snake_reg, snake_next;
    sweep_t sweep_reg, sweep_next;
    rnd_t   random_reg, random_next;
    logic   unknown, clear;
    logic [CMP_W-1:0] code_ext;

    assign code_ext = CMP_W'(code);

    always_comb begin
        mode_next   = mode_reg;
        before_next = before_reg;
        snake_next  = snake_reg;
        sweep_next  = sweep_reg;
        random_next = random_reg;
        unknown     = 1'b0;
        clear       = 1'b0;
        if (frame_evt) begin
            if (code_ext == CMP_W'(codes.power)) begin
                clear = 1'b1;
                if (mode_reg != MODE_OFF) begin
                    before_next = mode_reg;
                    mode_next   = MODE_OFF;
                end else begin
                    mode_next = before_reg;
                end
            end else if (code_ext == CMP_W'(codes.a)) begin
                mode_next = MODE_ONE;
                clear     = 1'b1;
            end else if (code_ext == CMP_W'(codes.b)) begin
                mode_next = MODE_TWO;
                clear     = 1'b1;
            end else if (code_ext == CMP_W'(codes.c)) begin
                mode_next = MODE_THREE;
                clear     = 1'b1;
            end else if (code_ext == CMP_W'(codes.up)) begin
                unique case (mode_reg)
                    MODE_ONE: begin
                        if (snake_reg < SNAKE_MAX) snake_next = snake_reg + SNAKE_STEP;
                    end
                    MODE_TWO: begin
                        if (sweep_reg > SWEEP_MIN) sweep_next = sweep_reg - SWEEP_STEP;
                    end
                    MODE_THREE: begin
                        if (random_reg > RANDOM_MIN) random_next = random_reg - RANDOM_STEP;
                    end
                    default: ;
                endcase
            end else if (code_ext == CMP_W'(codes.down)) begin
                unique case (mode_reg)
                    MODE_ONE: begin
                        if (snake_reg > SNAKE_MIN) snake_next = snake_reg - SNAKE_STEP;
                    end
                    MODE_TWO: begin
                        if (sweep_reg < SWEEP_MAX) sweep_next = sweep_reg + SWEEP_STEP;
                    end
                    MODE_THREE: begin
                        if (random_reg < RANDOM_MAX) random_next = random_reg + RANDOM_STEP;
                    end
                    default: ;
                endcase
            end else begin
                unknown = 1'b1;
            end
        end
    end

    assign status.unknown = unknown;
    assign status.clear   = clear;
    assign status.mode    = mode_next;
    assign status.snake   = snake_next;
    assign status.sweep   = sweep_next;
    assign status.random  = random_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_OFF;
            before_reg <= RST_MODE_BEFORE;
            snake_reg  <= RST_SNAKE;
            sweep_reg  <= RST_SWEEP;
            random_reg <= RST_RANDOM;
        end else if (step_en) begin
            mode_reg   <= mode_next;
            before_reg <= before_next;
            snake_reg  <= snake_next;
            sweep_reg  <= sweep_next;
            random_reg <= random_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/ir_pulse_decoder_mode_control.sv =====
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_interval_ticks
// m_        out        m_valid / m_ready   frame, code, flags and mode settings
// cfg_      in         cfg_wr_en           cfg_index, cfg_wdata
//
// One item per cycle unless the result stalls; items pass through the input and result registers.
// The threshold compare, frame count and mode update sit between the input and result registers.
// Reset is synchronous, active low, and loads the default codes and mode settings.
// A stalled result holds; an empty input register still takes an item while the result waits.
`default_nettype none

module ir_pulse_decoder_mode_control #(
    parameter int FRAME_EDGES = 36,
    parameter int CODE_BITS   = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [15:0]                      s_interval_ticks,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_frame_done,
    output logic [15:0]                           m_code_word,
    output logic                                  m_unknown_code,
    output logic                                  m_clear_strip,
    output logic [1:0]                            m_pattern_mode,
    output logic [3:0]                            m_snake_length,
    output logic [4:0]                            m_sweep_delay,
    output logic [5:0]                            m_random_delay,
    input  wire logic                             cfg_wr_en,
    input  wire logic [irpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [irpd_pkg::CFG_W-1:0]       cfg_wdata
);

    import irpd_pkg::*;

    localparam int CMP_W = (CODE_BITS > WORD_W) ? CODE_BITS : WORD_W;

    logic             in_valid_reg;
    logic [15:0]      ticks_reg;
    logic             advance;
    logic             bit_in;
    logic             frame_done;
    logic [CODE_BITS-1:0] code;
    logic [CMP_W-1:0] code_ext;
    mode_status_t     status;

    logic [CFG_W-1:0] threshold_reg;
    cfg_codes_t       codes_reg;

    logic             out_valid_reg;
    logic             done_reg;
    logic [15:0]      code_word_reg;
    mode_status_t     status_reg;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign bit_in  = (ticks_reg >= threshold_reg);
    assign code_ext = CMP_W'(code);

    irpd_frame_collector #(
        .FRAME_EDGES(FRAME_EDGES),
        .CODE_BITS  (CODE_BITS)
    ) u_collector (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .bit_in    (bit_in),
        .frame_done(frame_done),
        .code      (code)
    );

    irpd_mode_ctrl #(
        .CODE_BITS(CODE_BITS)
    ) u_mode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (advance),
        .frame_evt(advance && frame_done),
        .code     (code),
        .codes    (codes_reg),
        .status   (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= RST_THRESHOLD;
            codes_reg     <= '{power: RST_POWER, a: RST_A, b: RST_B, c: RST_C,
                               up: RST_UP, down: RST_DOWN};
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_THRESHOLD: threshold_reg  <= cfg_wdata;
                CFG_POWER:     codes_reg.power <= cfg_wdata;
                CFG_A:         codes_reg.a     <= cfg_wdata;
                CFG_B:         codes_reg.b     <= cfg_wdata;
                CFG_C:         codes_reg.c     <= cfg_wdata;
                CFG_UP:        codes_reg.up    <= cfg_wdata;
                CFG_DOWN:      codes_reg.down  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // hold the input item until the compute stage takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ticks_reg <= s_interval_ticks;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            done_reg      <= frame_done;
            code_word_reg <= frame_done ? code_ext[15:0] : 16'd0;
            status_reg    <= status;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_frame_done   = done_reg;
    assign m_code_word    = code_word_reg;
    assign m_unknown_code = status_reg.unknown;
    assign m_clear_strip  = status_reg.clear;
    assign m_pattern_mode = status_reg.mode;
    assign m_snake_length = status_reg.snake;
    assign m_sweep_delay  = status_reg.sweep;
    assign m_random_delay = status_reg.random;

`ifndef NO_ASSERTIONS
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_unknown_code && m_clear_strip))
        else $error("unknown and clear raised together");

    a_flags_need_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_unknown_code || m_clear_strip) |-> m_frame_done)
        else $error("flag raised without a completed frame");

    a_code_zero_midframe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_done |-> m_code_word == 16'd0)
        else $error("code word nonzero outside a frame end");

    a_snake_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_snake_length >= SNAKE_MIN) && (m_snake_length <= SNAKE_MAX))
        else $error("snake length out of range");

    a_no_input_stall_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled with a free stage");
`endif

endmodule

`default_nettype wire
